/* rtl/rtd_pkg.sv */
package rtd_pkg;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_UNLOAD = 3'd1,
    OP_TICK   = 3'd2,
    OP_CAS    = 3'd3,
    OP_SET    = 3'd4,
    OP_CLEAR  = 3'd5,
    OP_QUERY  = 3'd6,
    OP_RSVD   = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    ST_UNLOADED = 2'd0,
    ST_LOADING  = 2'd1,
    ST_LOADED   = 2'd2,
    ST_EVICTING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_NO_ENTRY      = 3'd1,
    ERR_ALREADY_UNLD  = 3'd2,
    ERR_ALREADY_EVICT = 3'd3,
    ERR_MISMATCH      = 3'd4,
    ERR_UNDERFLOW     = 3'd5
  } err_e;

  localparam logic [7:0] FRAME_MAX     = 8'd255;
  localparam logic [7:0] THRESHOLD_RST = 8'd10;
  localparam int unsigned MAX_RESULTS  = 64;
  localparam int unsigned FREE_CNT_W   = $clog2(MAX_RESULTS) + 1;

  // one result item
  typedef struct packed {
    logic        last;
    logic [5:0]  freed_handle;
    logic        freed_valid;
    logic [31:0] allocation;
    logic        has_allocation;
    logic [2:0]  error_code;
    logic        ok;
    logic        enqueue_load;
    logic [1:0]  status;
  } rtd_result_t;

  // operation handed to the update unit
  typedef struct packed {
    opcode_e     op;
    logic [1:0]  exp_status;
    logic [1:0]  swap_status;
    logic        in_range;
    logic        free_ok;
    logic [5:0]  handle;
  } rtd_cmd_t;

  // what the update unit asks of the store
  typedef struct packed {
    logic wr_en;
    logic present;
    logic freed;
  } rtd_ctl_t;

endpackage

/* rtl/residency_table_delayed_eviction.sv */
// Residency table with delayed eviction, indexed directly by handle. Each entry holds a
// presence bit, a status (unloaded/loading/loaded/evicting), a reference count, a frame
// age and an optional allocation word. Table operations (load, unload, status
// compare-swap, set/clear allocation, query) first read the entry from the one-read,
// one-write table store; then the shared update unit computes, writes back and
// registers the result, a step that waits while the output register still holds an
// untaken result. A frame tick sweeps the table one entry per cycle, save while a
// second freed result waits for the busy output register, through the same update
// unit, ageing evicting entries and freeing those that reach the threshold and hold an
// allocation. Each freed entry gives one result; a tick that frees nothing gives a
// single ok result. tlast marks the last result of an item. The input is not ready
// while an item is in progress, but a new item is taken while the previous result
// still waits in the output register. The threshold register (reset 10) must only be
// written while the block is idle. Presence bits clear at reset; no clearing pass is
// needed.
module residency_table_delayed_eviction import rtd_pkg::*; #(
  parameter int unsigned NUM_ENTRIES      = 64,
  parameter int unsigned REFCOUNT_WIDTH   = 16,
  parameter int unsigned ALLOCATION_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // opcode[2:0], handle[8:3], cmp_status[10:9], swap_status[12:11],
  // allocation_in[44:13], zero[47:45]
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // status[1:0], enqueue_load[2], ok[3], error_code[6:4], has_allocation[7],
  // allocation[39:8], freed_valid[40], freed_handle[46:41], zero[47]
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_wr_en_i,
  input  logic [7:0]  cfg_wr_data_i
);

  localparam int unsigned IdxW = $clog2(NUM_ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

  state_e                    state_q, state_d;
  opcode_e                   op_q, op_d;
  logic [5:0]                handle_q, handle_d;
  logic [1:0]                exp_q, exp_d;
  logic [1:0]                nst_q, nst_d;
  logic [31:0]               ain_q, ain_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic [FREE_CNT_W-1:0]     nfree_q, nfree_d;
  logic                      pend_valid_q, pend_valid_d;
  rtd_result_t               pend_q, pend_d;
  logic                      out_valid_q, out_valid_d;
  rtd_result_t               out_q, out_d;
  logic [7:0]                thr_q;

  // table store
  logic                        rd_en;
  logic [IdxW-1:0]             rd_addr;
  logic                        cur_present;
  logic [1:0]                  cur_status;
  logic [REFCOUNT_WIDTH-1:0]   cur_refs;
  logic [7:0]                  cur_frames;
  logic                        cur_has;
  logic [ALLOCATION_WIDTH-1:0] cur_alloc;
  logic                        wr_en;
  logic [IdxW-1:0]             wr_addr;

  // update unit
  rtd_cmd_t                    cmd;
  rtd_ctl_t                    ctl;
  rtd_result_t                 res;
  logic [1:0]                  nxt_status;
  logic [REFCOUNT_WIDTH-1:0]   nxt_refs;
  logic [7:0]                  nxt_frames;
  logic                        nxt_has;
  logic [ALLOCATION_WIDTH-1:0] nxt_alloc;

  logic        in_xfer;
  logic        out_free;
  logic        sweep_step;
  rtd_result_t tick_none;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  // output slot can take a new result this cycle
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    tick_none      = '0;
    tick_none.ok   = 1'b1;
    tick_none.last = 1'b1;
  end

  always_comb begin
    cmd             = '0;
    cmd.op          = op_q;
    cmd.exp_status  = exp_q;
    cmd.swap_status = nst_q;
    cmd.in_range    = 32'(handle_q) < 32'(NUM_ENTRIES);
    cmd.free_ok     = nfree_q < FREE_CNT_W'(MAX_RESULTS);
    cmd.handle      = (state_q == S_SWEEP) ? 6'(idx_q) : handle_q;
  end

  rtd_update #(
    .RefW   (REFCOUNT_WIDTH),
    .AllocW (ALLOCATION_WIDTH)
  ) u_update (
    .cmd_i         (cmd),
    .alloc_in_i    (ain_q),
    .threshold_i   (thr_q),
    .cur_present_i (cur_present),
    .cur_status_i  (cur_status),
    .cur_refs_i    (cur_refs),
    .cur_frames_i  (cur_frames),
    .cur_has_i     (cur_has),
    .cur_alloc_i   (cur_alloc),
    .ctl_o         (ctl),
    .nxt_status_o  (nxt_status),
    .nxt_refs_o    (nxt_refs),
    .nxt_frames_o  (nxt_frames),
    .nxt_has_o     (nxt_has),
    .nxt_alloc_o   (nxt_alloc),
    .res_o         (res)
  );

  rtd_store #(
    .NumEntries (NUM_ENTRIES),
    .RefW       (REFCOUNT_WIDTH),
    .AllocW     (ALLOCATION_WIDTH)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (rd_en),
    .rd_addr_i    (rd_addr),
    .rd_present_o (cur_present),
    .rd_status_o  (cur_status),
    .rd_refs_o    (cur_refs),
    .rd_frames_o  (cur_frames),
    .rd_has_o     (cur_has),
    .rd_alloc_o   (cur_alloc),
    .wr_en_i      (wr_en),
    .wr_addr_i    (wr_addr),
    .wr_present_i (ctl.present),
    .wr_status_i  (nxt_status),
    .wr_refs_i    (nxt_refs),
    .wr_frames_i  (nxt_frames),
    .wr_has_i     (nxt_has),
    .wr_alloc_i   (nxt_alloc)
  );

  // a sweep step stalls only when a second freed result needs the busy output slot
  assign sweep_step = !(ctl.freed && pend_valid_q && !out_free);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    handle_d     = handle_q;
    exp_d        = exp_q;
    nst_d        = nst_q;
    ain_d        = ain_q;
    idx_d        = idx_q;
    nfree_d      = nfree_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    rd_en        = 1'b0;
    rd_addr      = idx_q + IdxW'(1);
    wr_en        = 1'b0;
    wr_addr      = (state_q == S_SWEEP) ? idx_q : IdxW'(handle_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d     = opcode_e'(s_axis_tdata[2:0]);
          handle_d = s_axis_tdata[8:3];
          exp_d    = s_axis_tdata[10:9];
          nst_d    = s_axis_tdata[12:11];
          ain_d    = s_axis_tdata[44:13];
          rd_en    = 1'b1;
          if (opcode_e'(s_axis_tdata[2:0]) == OP_TICK) begin
            rd_addr      = '0;
            idx_d        = '0;
            nfree_d      = '0;
            pend_valid_d = 1'b0;
            state_d      = S_SWEEP;
          end else begin
            rd_addr = IdxW'(s_axis_tdata[8:3]);
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          wr_en       = ctl.wr_en;
          out_d       = res;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (sweep_step) begin
          wr_en = ctl.wr_en;
          if (ctl.freed) begin
            nfree_d = nfree_q + FREE_CNT_W'(1);
            if (pend_valid_q) begin
              // earlier free is not the last one: release it
              out_d       = pend_q;
              out_valid_d = 1'b1;
            end
            pend_d       = res;
            pend_valid_d = 1'b1;
          end
          if (idx_q == LastIdx) begin
            state_d = S_FLUSH;
          end else begin
            idx_d = idx_q + IdxW'(1);
            rd_en = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          if (pend_valid_q) begin
            out_d      = pend_q;
            out_d.last = 1'b1;
          end else begin
            out_d = tick_none;
          end
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      nfree_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      thr_q        <= THRESHOLD_RST;
    end else begin
      state_q      <= state_d;
      nfree_q      <= nfree_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_wr_en_i) begin
        thr_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    handle_q <= handle_d;
    exp_q    <= exp_d;
    nst_q    <= nst_d;
    ain_q    <= ain_d;
    idx_q    <= idx_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {1'b0, out_q.freed_handle, out_q.freed_valid, out_q.allocation,
                          out_q.has_allocation, out_q.error_code, out_q.ok,
                          out_q.enqueue_load, out_q.status};

endmodule

/* rtl/rtd_store.sv */
module rtd_store import rtd_pkg::*; #(
  parameter int unsigned NumEntries = 64,
  parameter int unsigned RefW       = 16,
  parameter int unsigned AllocW     = 32,
  localparam int unsigned IdxW      = $clog2(NumEntries)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [IdxW-1:0]   rd_addr_i,
  output logic              rd_present_o,
  output logic [1:0]        rd_status_o,
  output logic [RefW-1:0]   rd_refs_o,
  output logic [7:0]        rd_frames_o,
  output logic              rd_has_o,
  output logic [AllocW-1:0] rd_alloc_o,
  input  logic              wr_en_i,
  input  logic [IdxW-1:0]   wr_addr_i,
  input  logic              wr_present_i,
  input  logic [1:0]        wr_status_i,
  input  logic [RefW-1:0]   wr_refs_i,
  input  logic [7:0]        wr_frames_i,
  input  logic              wr_has_i,
  input  logic [AllocW-1:0] wr_alloc_i
);

  localparam int unsigned EntW = 2 + RefW + 8 + 1 + AllocW;

  logic [EntW-1:0]       mem [NumEntries];
  logic [EntW-1:0]       rd_q;
  logic [NumEntries-1:0] present_q;
  logic                  rd_present_q;

  // entry body: no reset, only used while present
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_status_i, wr_refs_i, wr_frames_i, wr_has_i, wr_alloc_i};
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q    <= '0;
      rd_present_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        present_q[wr_addr_i] <= wr_present_i;
      end
      if (rd_en_i) begin
        rd_present_q <= present_q[rd_addr_i];
      end
    end
  end

  assign rd_present_o = rd_present_q;
  assign rd_alloc_o   = rd_q[AllocW-1:0];
  assign rd_has_o     = rd_q[AllocW];
  assign rd_frames_o  = rd_q[AllocW+8:AllocW+1];
  assign rd_refs_o    = rd_q[AllocW+8+RefW:AllocW+9];
  assign rd_status_o  = rd_q[EntW-1:EntW-2];

endmodule

/* rtl/rtd_update.sv */
module rtd_update import rtd_pkg::*; #(
  parameter int unsigned RefW   = 16,
  parameter int unsigned AllocW = 32
) (
  input  rtd_cmd_t          cmd_i,
  input  logic [31:0]       alloc_in_i,
  input  logic [7:0]        threshold_i,
  input  logic              cur_present_i,
  input  logic [1:0]        cur_status_i,
  input  logic [RefW-1:0]   cur_refs_i,
  input  logic [7:0]        cur_frames_i,
  input  logic              cur_has_i,
  input  logic [AllocW-1:0] cur_alloc_i,
  output rtd_ctl_t          ctl_o,
  output logic [1:0]        nxt_status_o,
  output logic [RefW-1:0]   nxt_refs_o,
  output logic [7:0]        nxt_frames_o,
  output logic              nxt_has_o,
  output logic [AllocW-1:0] nxt_alloc_o,
  output rtd_result_t       res_o
);

  logic [7:0] frames_inc;
  logic       entry_res;
  logic       ok;
  logic       enq;
  err_e       err;

  assign frames_inc = (cur_frames_i == FRAME_MAX) ? cur_frames_i : cur_frames_i + 8'd1;

  always_comb begin
    ctl_o         = '0;
    ctl_o.present = cur_present_i;
    nxt_status_o  = cur_status_i;
    nxt_refs_o    = cur_refs_i;
    nxt_frames_o  = cur_frames_i;
    nxt_has_o     = cur_has_i;
    nxt_alloc_o   = cur_alloc_i;
    entry_res     = 1'b0;
    ok            = 1'b0;
    enq           = 1'b0;
    err           = ERR_NONE;
    res_o         = '0;
    res_o.last    = 1'b1;

    unique case (cmd_i.op)
      OP_TICK: begin
        // one sweep step: age an evicting entry, free it once old enough if it holds an allocation
        res_o.last = 1'b0;
        if (cur_present_i && (cur_status_i == ST_EVICTING)) begin
          ctl_o.wr_en  = 1'b1;
          nxt_frames_o = frames_inc;
          if ((frames_inc >= threshold_i) && cur_has_i && cmd_i.free_ok) begin
            ctl_o.present        = 1'b0;
            ctl_o.freed          = 1'b1;
            res_o.ok             = 1'b1;
            res_o.has_allocation = 1'b1;
            res_o.allocation     = 32'(cur_alloc_i);
            res_o.freed_valid    = 1'b1;
            res_o.freed_handle   = cmd_i.handle;
          end
        end
      end
      OP_RSVD: begin
        // no change, empty result
      end
      default: begin
        if (!cmd_i.in_range || ((cmd_i.op != OP_LOAD) && !cur_present_i)) begin
          res_o.error_code = ERR_NO_ENTRY;
        end else begin
          entry_res = 1'b1;
          unique case (cmd_i.op)
            OP_LOAD: begin
              if (!cur_present_i) begin
                nxt_status_o = ST_UNLOADED;
                nxt_refs_o   = '0;
                nxt_has_o    = 1'b0;
                nxt_alloc_o  = '0;
              end
              if (nxt_refs_o != '1) begin
                nxt_refs_o = nxt_refs_o + RefW'(1);
              end
              nxt_frames_o = 8'd0;
              if (nxt_status_o == ST_UNLOADED) begin
                nxt_status_o = ST_LOADING;
                enq          = 1'b1;
              end else if (nxt_status_o == ST_EVICTING) begin
                nxt_status_o = ST_LOADED;
              end
              ctl_o.wr_en   = 1'b1;
              ctl_o.present = 1'b1;
              ok            = 1'b1;
            end
            OP_UNLOAD: begin
              if (cur_refs_i == '0) begin
                err = ERR_UNDERFLOW;
              end else begin
                nxt_refs_o  = cur_refs_i - RefW'(1);
                ctl_o.wr_en = 1'b1;
                if (nxt_refs_o != '0) begin
                  ok = 1'b1;
                end else if (cur_status_i == ST_UNLOADED) begin
                  err = ERR_ALREADY_UNLD;
                end else if (cur_status_i == ST_EVICTING) begin
                  err = ERR_ALREADY_EVICT;
                end else begin
                  nxt_status_o = ST_EVICTING;
                  ok           = 1'b1;
                end
              end
            end
            OP_CAS: begin
              if (cur_status_i == cmd_i.exp_status) begin
                nxt_status_o = cmd_i.swap_status;
                ctl_o.wr_en  = 1'b1;
                ok           = 1'b1;
              end else begin
                err = ERR_MISMATCH;
              end
            end
            OP_SET: begin
              nxt_has_o   = 1'b1;
              nxt_alloc_o = AllocW'(alloc_in_i);
              ctl_o.wr_en = 1'b1;
              ok          = 1'b1;
            end
            OP_CLEAR: begin
              nxt_has_o   = 1'b0;
              nxt_alloc_o = '0;
              ctl_o.wr_en = 1'b1;
              ok          = 1'b1;
            end
            default: begin
              // query
              ok = 1'b1;
            end
          endcase
        end
      end
    endcase

    if (entry_res) begin
      res_o.status         = nxt_status_o;
      res_o.enqueue_load   = enq;
      res_o.ok             = ok;
      res_o.error_code     = err;
      res_o.has_allocation = nxt_has_o;
      res_o.allocation     = nxt_has_o ? 32'(nxt_alloc_o) : 32'd0;
    end
  end

endmodule

/* bench/tb_top.sv */
// Residency table bench: a queue of table operations feeds a bursty stream driver,
// a table model predicts every result, and a monitor compares each result
// transfer field by field against the oldest prediction.
module tb_top;
  import rtd_pkg::*;

  localparam int unsigned N_ENTRIES = 64;
  localparam logic [15:0] REFS_MAX  = 16'hFFFF;
  // a tick sweeps the whole table and may keep ageing after its last free
  localparam int unsigned SWEEP_CYCLES = N_ENTRIES + 8;
  // longest stretch with no transfer on either side before giving up
  localparam int unsigned QUIET_LIMIT  = 5000;

  // one table operation as it travels on the input stream
  typedef struct packed {
    opcode_e     op;
    logic [5:0]  handle;
    status_e     exp_st;
    status_e     new_st;
    logic [31:0] alloc_in;
  } table_op_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [47:0] s_data = '0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_ready = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  residency_table_delayed_eviction dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Table model: own copy of every entry and of the eviction threshold
  // ---------------------------------------------------------------------------
  logic        tbl_present   [N_ENTRIES];
  status_e     tbl_status    [N_ENTRIES];
  logic [15:0] tbl_refs      [N_ENTRIES];
  logic [7:0]  tbl_frames    [N_ENTRIES];
  logic        tbl_has_alloc [N_ENTRIES];
  logic [31:0] tbl_alloc     [N_ENTRIES];
  logic [7:0]  threshold = THRESHOLD_RST;

  table_op_t   pending_ops_q [$];   // operations not yet handed to the driver
  rtd_result_t due_results_q [$];   // predicted results, oldest first

  int unsigned n_queued = 0;        // operations put on pending_ops_q so far
  int unsigned n_sent   = 0;        // operations accepted by the block
  int unsigned n_errors = 0;

  function automatic void clear_entry(input int unsigned h);
    tbl_present[h]   = 1'b0;
    tbl_status[h]    = ST_UNLOADED;
    tbl_refs[h]      = '0;
    tbl_frames[h]    = '0;
    tbl_has_alloc[h] = 1'b0;
    tbl_alloc[h]     = '0;
  endfunction

  // entry as it looks after the operation
  function automatic rtd_result_t entry_result(input logic [5:0] h, input logic enq,
                                               input logic ok, input err_e err);
    rtd_result_t r;
    r = '0;
    r.status         = tbl_status[h];
    r.enqueue_load   = enq;
    r.ok             = ok;
    r.error_code     = err;
    r.has_allocation = tbl_has_alloc[h];
    r.allocation     = tbl_has_alloc[h] ? tbl_alloc[h] : '0;
    r.last           = 1'b1;
    return r;
  endfunction

  // updates the table for one accepted operation and queues its results
  task automatic apply_table_op(input table_op_t t);
    rtd_result_t r;
    rtd_result_t prev;
    logic        have_prev;
    int unsigned n_freed;
    logic [5:0]  h;
    logic        enq;
    h = t.handle;
    r = '0;
    r.last = 1'b1;
    if (t.op == OP_TICK) begin
      n_freed   = 0;
      have_prev = 1'b0;
      prev      = '0;
      for (int i = 0; i < N_ENTRIES; i++) begin
        if (tbl_present[i] && tbl_status[i] == ST_EVICTING) begin
          if (tbl_frames[i] != FRAME_MAX) tbl_frames[i]++;
          if (tbl_frames[i] >= threshold && tbl_has_alloc[i] && n_freed < MAX_RESULTS) begin
            // hold each free back until we know whether it is the last one
            if (have_prev) due_results_q.push_back(prev);
            prev                = '0;
            prev.ok             = 1'b1;
            prev.has_allocation = 1'b1;
            prev.allocation     = tbl_alloc[i];
            prev.freed_valid    = 1'b1;
            prev.freed_handle   = 6'(i);
            have_prev = 1'b1;
            n_freed++;
            clear_entry(i);
          end
        end
      end
      if (!have_prev) prev.ok = 1'b1;
      prev.last = 1'b1;
      due_results_q.push_back(prev);
    end else if (t.op == OP_RSVD) begin
      due_results_q.push_back(r);
    end else if (t.op != OP_LOAD && !tbl_present[h]) begin
      r.error_code = ERR_NO_ENTRY;
      due_results_q.push_back(r);
    end else begin
      case (t.op)
        OP_LOAD: begin
          enq = 1'b0;
          if (!tbl_present[h]) begin
            clear_entry(h);
            tbl_present[h] = 1'b1;
          end
          if (tbl_refs[h] != REFS_MAX) tbl_refs[h]++;
          tbl_frames[h] = '0;
          if (tbl_status[h] == ST_UNLOADED) begin
            tbl_status[h] = ST_LOADING;
            enq = 1'b1;
          end else if (tbl_status[h] == ST_EVICTING) begin
            tbl_status[h] = ST_LOADED;
          end
          due_results_q.push_back(entry_result(h, enq, 1'b1, ERR_NONE));
        end
        OP_UNLOAD: begin
          if (tbl_refs[h] == '0) begin
            due_results_q.push_back(entry_result(h, 1'b0, 1'b0, ERR_UNDERFLOW));
          end else begin
            tbl_refs[h]--;
            if (tbl_refs[h] != '0) begin
              due_results_q.push_back(entry_result(h, 1'b0, 1'b1, ERR_NONE));
            end else if (tbl_status[h] == ST_UNLOADED) begin
              due_results_q.push_back(entry_result(h, 1'b0, 1'b0, ERR_ALREADY_UNLD));
            end else if (tbl_status[h] == ST_EVICTING) begin
              due_results_q.push_back(entry_result(h, 1'b0, 1'b0, ERR_ALREADY_EVICT));
            end else begin
              tbl_status[h] = ST_EVICTING;
              due_results_q.push_back(entry_result(h, 1'b0, 1'b1, ERR_NONE));
            end
          end
        end
        OP_CAS: begin
          if (tbl_status[h] == t.exp_st) begin
            tbl_status[h] = t.new_st;
            due_results_q.push_back(entry_result(h, 1'b0, 1'b1, ERR_NONE));
          end else begin
            due_results_q.push_back(entry_result(h, 1'b0, 1'b0, ERR_MISMATCH));
          end
        end
        OP_SET: begin
          tbl_has_alloc[h] = 1'b1;
          tbl_alloc[h]     = t.alloc_in;
          due_results_q.push_back(entry_result(h, 1'b0, 1'b1, ERR_NONE));
        end
        OP_CLEAR: begin
          tbl_has_alloc[h] = 1'b0;
          tbl_alloc[h]     = '0;
          due_results_q.push_back(entry_result(h, 1'b0, 1'b1, ERR_NONE));
        end
        default: begin
          due_results_q.push_back(entry_result(h, 1'b0, 1'b1, ERR_NONE));
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endtask

  function automatic table_op_t t_of(input logic [47:0] d);
    table_op_t t;
    t.op       = opcode_e'(d[2:0]);
    t.handle   = d[8:3];
    t.exp_st   = status_e'(d[10:9]);
    t.new_st   = status_e'(d[12:11]);
    t.alloc_in = d[44:13];
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: both transfers sampled at the rising edge
  // ---------------------------------------------------------------------------
  logic        in_taken = 1'b0;
  rtd_result_t got_res;
  rtd_result_t want_res;

  always @(posedge clk_i) begin
    in_taken <= s_valid && s_ready && rst_ni;
    if (rst_ni) begin
      if (cfg_wr_en) threshold = cfg_wr_data;
      if (m_axis_tvalid && m_ready) begin
        // result struct is laid out exactly as {tlast, tdata[46:0]}
        got_res = rtd_result_t'({m_axis_tlast, m_axis_tdata[46:0]});
        if (due_results_q.size() == 0) begin
          $error("result transfer with nothing predicted: tdata 0x%0h", m_axis_tdata);
          n_errors++;
        end else begin
          want_res = due_results_q.pop_front();
          check_field("status",         32'(want_res.status),       32'(got_res.status));
          check_field("enqueue_load",   32'(want_res.enqueue_load),
                      32'(got_res.enqueue_load));
          check_field("ok",             32'(want_res.ok),           32'(got_res.ok));
          check_field("error_code",     32'(want_res.error_code),   32'(got_res.error_code));
          check_field("has_allocation", 32'(want_res.has_allocation),
                      32'(got_res.has_allocation));
          check_field("allocation",     want_res.allocation,        got_res.allocation);
          check_field("freed_valid",    32'(want_res.freed_valid),
                      32'(got_res.freed_valid));
          check_field("freed_handle",   32'(want_res.freed_handle),
                      32'(got_res.freed_handle));
          check_field("last",           32'(want_res.last),         32'(got_res.last));
        end
      end
      // predict after popping so a same-edge result never meets its own item
      if (s_valid && s_ready) begin
        apply_table_op(t_of(s_data));
        n_sent++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of transfers separated by random gaps, changes on falling edge
  // ---------------------------------------------------------------------------
  logic        no_gaps    = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  table_op_t   next_op;

  always @(negedge clk_i) begin
    if (rst_ni && (!s_valid || in_taken)) begin
      if (gap_left != 0 && !no_gaps) begin
        gap_left--;
        s_valid <= 1'b0;
      end else if (pending_ops_q.size() != 0) begin
        next_op = pending_ops_q.pop_front();
        s_data  <= {3'b000, next_op.alloc_in, next_op.new_st, next_op.exp_st,
                    next_op.handle, next_op.op};
        s_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          // a quarter of the bursts run straight on, giving gap-free stretches
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall behaviour switches between modes every so often
  // ---------------------------------------------------------------------------
  int unsigned  rx_mode      = 0;
  int unsigned  rx_mode_left = 0;
  logic [11:0]  rx_pattern   = 12'b1101_0011_1001;

  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(20, 300);
    end else begin
      rx_mode_left--;
    end
    rx_pattern = {rx_pattern[10:0], rx_pattern[11]};
    case (rx_mode)
      0:       m_ready <= 1'b1;
      1:       m_ready <= ($urandom_range(0, 3) != 0);
      2:       m_ready <= rx_pattern[0];
      default: m_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a run with no transfer for too long has hung
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_axis_tvalid && m_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_op(input opcode_e op, input logic [5:0] h,
                         input status_e e = ST_UNLOADED, input status_e n = ST_UNLOADED,
                         input logic [31:0] a = '0);
    table_op_t t;
    t.op       = op;
    t.handle   = h;
    t.exp_st   = e;
    t.new_st   = n;
    t.alloc_in = a;
    pending_ops_q.push_back(t);
    n_queued++;
  endtask

  // the sender holds off here until every predicted result has come back
  task automatic wait_drained();
    while (n_sent != n_queued || due_results_q.size() != 0) @(negedge clk_i);
  endtask

  // only written while idle, once every predicted result is back and the extra sweep wait is over
  task automatic write_threshold(input logic [7:0] v);
    wait_drained();
    repeat (SWEEP_CYCLES) @(negedge clk_i);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk_i);
    cfg_wr_en   <= 1'b0;
  endtask

  // mostly well-formed entry lifetimes on a few hot handles, the rest noise
  task automatic random_phase(input int unsigned n_ops);
    logic [5:0]  pool [8];
    logic [5:0]  h;
    int unsigned start;
    int unsigned k;
    start = n_queued;
    foreach (pool[i]) pool[i] = 6'($urandom_range(0, 63));
    while (n_queued - start < n_ops) begin
      h = pool[$urandom_range(0, 7)];
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          k = $urandom_range(1, 3);
          repeat (k) push_op(OP_LOAD, h);
          if ($urandom_range(0, 3) != 0) push_op(OP_CAS, h, ST_LOADING, ST_LOADED);
          else push_op(OP_CAS, h, status_e'($urandom_range(0, 3)),
                       status_e'($urandom_range(0, 3)));
          if ($urandom_range(0, 3) != 0) push_op(OP_SET, h, ST_UNLOADED, ST_UNLOADED,
                                                 $urandom());
          if ($urandom_range(0, 4) == 0) push_op(OP_CLEAR, h);
          if ($urandom_range(0, 2) == 0) push_op(OP_QUERY, h);
          // now and then one unload too many, to hit the underflow path
          repeat (k + ($urandom_range(0, 5) == 0)) push_op(OP_UNLOAD, h);
        end
        6, 7: begin
          repeat ($urandom_range(1, 3))
            push_op(OP_TICK, h, status_e'($urandom_range(0, 3)),
                    status_e'($urandom_range(0, 3)), $urandom());
        end
        default: begin
          push_op(opcode_e'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                  status_e'($urandom_range(0, 3)), status_e'($urandom_range(0, 3)),
                  $urandom());
        end
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < N_ENTRIES; i++) clear_entry(i);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: absent entries, reserved opcode, every error code, reset threshold
    push_op(OP_QUERY, 6'd0);
    push_op(OP_UNLOAD, 6'd63);
    push_op(OP_RSVD, 6'd63, ST_EVICTING, ST_EVICTING, 32'hFFFF_FFFF);
    push_op(OP_TICK, 6'd0);
    push_op(OP_LOAD, 6'd63);
    push_op(OP_LOAD, 6'd63);
    push_op(OP_CAS, 6'd63, ST_LOADED, ST_EVICTING);      // mismatch
    push_op(OP_CAS, 6'd63, ST_LOADING, ST_LOADED);
    push_op(OP_SET, 6'd63, ST_UNLOADED, ST_UNLOADED, 32'hFFFF_FFFF);
    push_op(OP_QUERY, 6'd63);
    push_op(OP_UNLOAD, 6'd63);
    push_op(OP_UNLOAD, 6'd63);                           // loaded -> evicting
    push_op(OP_UNLOAD, 6'd63);                           // count underflow
    push_op(OP_TICK, 6'd0);
    push_op(OP_LOAD, 6'd0);
    push_op(OP_CAS, 6'd0, ST_LOADING, ST_UNLOADED);
    push_op(OP_UNLOAD, 6'd0);                            // already unloaded
    push_op(OP_SET, 6'd0, ST_UNLOADED, ST_UNLOADED, 32'h0);
    push_op(OP_LOAD, 6'd1);
    push_op(OP_SET, 6'd1, ST_UNLOADED, ST_UNLOADED, 32'hA5A5_5A5A);
    push_op(OP_CLEAR, 6'd1);
    push_op(OP_CAS, 6'd1, ST_LOADING, ST_EVICTING);
    push_op(OP_UNLOAD, 6'd1);                            // already evicting
    push_op(OP_LOAD, 6'd1);                              // evicting -> loaded
    push_op(OP_UNLOAD, 6'd1);

    // threshold 1: several entries evicting with an allocation, one tick frees all
    write_threshold(8'd1);
    no_gaps = 1'b1;
    for (int i = 0; i < 8; i++) begin
      push_op(OP_LOAD, 6'(i * 7));
      push_op(OP_CAS, 6'(i * 7), ST_LOADING, ST_LOADED);
      push_op(OP_SET, 6'(i * 7), ST_UNLOADED, ST_UNLOADED, $urandom());
      push_op(OP_UNLOAD, 6'(i * 7));
    end
    push_op(OP_TICK, 6'd0);
    push_op(OP_QUERY, 6'd0);
    wait_drained();
    no_gaps = 1'b0;

    write_threshold(8'($urandom_range(1, 4)));
    random_phase(22);
    write_threshold(8'd1);
    random_phase(22);
    write_threshold(THRESHOLD_RST);
    random_phase(22);
    write_threshold(8'($urandom_range(2, 6)));
    random_phase(22);

    wait_drained();
    repeat (SWEEP_CYCLES) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/rtd_pkg.sv
rtl/rtd_store.sv
rtl/rtd_update.sv
rtl/residency_table_delayed_eviction.sv
bench/tb_top.sv
